// ----- hw/rtl/pegasos_svm_sgd_trainer_macros.svh -----
// assertion macros for the pegasos trainer
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef PEGASOS_SVM_SGD_TRAINER_MACROS_SVH
`define PEGASOS_SVM_SGD_TRAINER_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define SVM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SVM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SVM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SVM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/pss_pkg.sv -----
// shared constants, codes and saturation helpers for the pegasos trainer
// no dependencies
`timescale 1ns / 1ps
package pss_pkg;
   localparam int MAX_DIM   = 1024;
   localparam int MUL_W     = 33;
   localparam int PROD_W    = 66;
   localparam int DIV_NUM_W = 49;
   localparam int DIV_DEN_W = 65;
   localparam int ETA_W     = 20;

   localparam logic [2:0] REG_LAMBDA      = 3'd0;
   localparam logic [2:0] REG_OFFSET      = 3'd1;
   localparam logic [2:0] REG_BIAS_MULT   = 3'd2;
   localparam logic [2:0] REG_BIAS_RATE   = 3'd3;
   localparam logic [2:0] REG_ACTIVE_LEN  = 3'd4;

   localparam logic OP_FEATURE  = 1'b0;
   localparam logic OP_READ     = 1'b1;
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   localparam logic [31:0] LAMBDA_RST     = 32'd429497;
   localparam logic [31:0] OFFSET_RST     = 32'd10000;
   localparam logic [30:0] BIAS_MULT_RST  = 31'd0;
   localparam logic [30:0] BIAS_RATE_RST  = 31'd65536;
   localparam logic [10:0] ACTIVE_LEN_RST = 11'd1024;

   localparam logic [30:0] RATE_MAX = 31'h7FFF_FFFF;
   localparam logic [ETA_W-1:0] ETA_NUM = 20'd655360;
   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
   localparam logic [3:0] SHRINK_PERIOD = 4'd10;

   function automatic logic [31:0] sat32(input logic signed [PROD_W-1:0] v);
      logic [31:0] r;
      if (v > $signed(PROD_W'(32'h7FFF_FFFF))) r = 32'h7FFF_FFFF;
      else if (v < -$signed(PROD_W'(33'h0_8000_0000))) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // non-negative product factor clipped to the largest positive word
   function automatic logic [30:0] sat_fac(input logic signed [PROD_W-1:0] v);
      logic [30:0] r;
      if (v > $signed(PROD_W'(RATE_MAX))) r = RATE_MAX;
      else r = v[30:0];
      return r;
   endfunction
endpackage

// ----- hw/rtl/pss_ifs.sv -----
// valid/ready channel interfaces for request and response words
// depends on nothing
`timescale 1ns / 1ps
interface pss_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] feature_value;
   logic        label_positive;
   logic        last_element;
   logic [10:0] read_index;
   modport source (output valid, op, feature_value, label_positive, last_element, read_index,
                   input ready);
   modport sink   (input valid, op, feature_value, label_positive, last_element, read_index,
                   output ready);
endinterface

interface pss_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] weight_value;
   logic        margin_violated;
   logic [31:0] score;
   logic [31:0] iteration;
   logic        length_error;
   modport source (output valid, kind, weight_value, margin_violated, score, iteration,
                   length_error, input ready);
   modport sink   (input valid, kind, weight_value, margin_violated, score, iteration,
                   length_error, output ready);
endinterface

// ----- hw/rtl/pss_mul.sv -----
// shared signed multiplier with registered product
// depends on pss_pkg
`timescale 1ns / 1ps
module pss_mul (
   input  logic                                 clock,
   input  logic signed [pss_pkg::MUL_W-1:0]     a,
   input  logic signed [pss_pkg::MUL_W-1:0]     b,
   output logic signed [pss_pkg::PROD_W-1:0]    p
);
   logic signed [pss_pkg::PROD_W-1:0] p_ff;
   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end
   assign p = p_ff;
endmodule

// ----- hw/rtl/pss_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on pss_pkg
`timescale 1ns / 1ps
module pss_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [pss_pkg::DIV_NUM_W-1:0]     num,
   input  logic [pss_pkg::DIV_DEN_W-1:0]     den,
   output logic                              busy,
   output logic                              done,
   output logic [pss_pkg::DIV_NUM_W-1:0]     quot
);
   localparam int NW = pss_pkg::DIV_NUM_W;
   localparam int DW = pss_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [NW-1:0] num_ff, num_in, q_ff, q_in;
   logic [DW:0]   rem_sh, diff;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NW-1]};
      diff    = rem_sh - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         num_in  = num;
         q_in    = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = diff[DW-1:0];
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DW-1:0];
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ----- hw/rtl/pegasos_svm_sgd_trainer.sv -----
// pegasos linear svm trainer top level: sequencer, weight and sample memories
// depends on pss_pkg, pss_ifs, pss_mul, pss_div and the assertion macro header
`timescale 1ns / 1ps
`include "pegasos_svm_sgd_trainer_macros.svh"

// trains a linear svm by pegasos stochastic sub-gradient descent in saturating
// q16.16. feature words stream in one per cycle while the block is idle and
// land in a sample buffer; a feature word without last_element leaves the
// block idle and gives no response. the word that carries last_element runs
// one iteration on a sequencer that drives a single shared multiplier and a
// bit-serial divider: the rate product and the rate division, then on every
// tenth iteration the shrink factor division and a shrink pass over the
// active weights, then the dot product over the features, the update when
// the margin is violated, and the bias. the block is not ready while an
// iteration runs; a finished status word waits in an output register so new
// feature words are taken meanwhile. a read word is answered after a weight
// read step and a select step. after reset a clearing pass writes zero to
// every weight, one entry per cycle, before the first word is accepted.
// configuration writes take effect at once and belong only to idle time.
module pegasos_svm_sgd_trainer #(
   parameter int MAX_DIM = pss_pkg::MAX_DIM
) (
   input  logic          clock,
   input  logic          reset,
   pss_req_if.sink       req_chan,
   pss_rsp_if.source     rsp_chan,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_wdata
);
   localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int LEN_W  = $clog2(MAX_DIM + 1);
   localparam int PW     = pss_pkg::PROD_W;
   localparam int MW     = pss_pkg::MUL_W;
   localparam int EW     = pss_pkg::ETA_W;

   // sequencer codes
   localparam logic [4:0] S_CLEAR  = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_RDW    = 5'd2;
   localparam logic [4:0] S_RDD    = 5'd3;
   localparam logic [4:0] S_MULS   = 5'd4;
   localparam logic [4:0] S_MULW   = 5'd5;
   localparam logic [4:0] S_DRATE  = 5'd6;
   localparam logic [4:0] S_PRESH  = 5'd7;
   localparam logic [4:0] S_DETA   = 5'd8;
   localparam logic [4:0] S_SHCHK  = 5'd9;
   localparam logic [4:0] S_SHRD   = 5'd10;
   localparam logic [4:0] S_SHMUL  = 5'd11;
   localparam logic [4:0] S_SHWR   = 5'd12;
   localparam logic [4:0] S_BS1    = 5'd13;
   localparam logic [4:0] S_BS2    = 5'd14;
   localparam logic [4:0] S_BS3    = 5'd15;
   localparam logic [4:0] S_DOTCHK = 5'd16;
   localparam logic [4:0] S_DOTRD  = 5'd17;
   localparam logic [4:0] S_DOTMUL = 5'd18;
   localparam logic [4:0] S_DOTACC = 5'd19;
   localparam logic [4:0] S_DB1    = 5'd20;
   localparam logic [4:0] S_DB2    = 5'd21;
   localparam logic [4:0] S_SCORE  = 5'd22;
   localparam logic [4:0] S_UPCHK  = 5'd23;
   localparam logic [4:0] S_UPRD   = 5'd24;
   localparam logic [4:0] S_UPMUL  = 5'd25;
   localparam logic [4:0] S_UPWR   = 5'd26;
   localparam logic [4:0] S_BU1    = 5'd27;
   localparam logic [4:0] S_BU2    = 5'd28;
   localparam logic [4:0] S_BU3    = 5'd29;
   localparam logic [4:0] S_DONE   = 5'd30;

   // configuration registers
   logic [31:0] lambda_ff, offset_ff;
   logic [30:0] bmult_ff, brate_ff;
   logic [10:0] alen_ff;

   // model and sequencing state
   logic [4:0]        state_ff, state_in;
   logic [LEN_W-1:0]  idx_ff, idx_in, pos_ff, pos_in;
   logic              ovf_ff, ovf_in;
   logic [31:0]       iter_ff, iter_in, bias_ff, bias_in;
   logic [3:0]        mod_ff, mod_in;
   logic              lbl_ff, lbl_in;
   logic [10:0]       ridx_ff, ridx_in;
   logic [32:0]       s_ff, s_in;
   logic [30:0]       rate_ff, rate_in;
   logic [EW-1:0]     eta_ff, eta_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic [31:0]       score_ff, score_in;
   logic              viol_ff, viol_in;
   logic              rkind_ff, rkind_in;
   logic [31:0]       rword_ff, rword_in;

   // response register
   logic        rv_ff, rv_in, ok_ff, ok_in, ov_ff, ov_in, ol_ff, ol_in;
   logic [31:0] ow_ff, ow_in, os_ff, os_in, oi_ff, oi_in;

   // memories
   logic [31:0]       weight_mem_ff [MAX_DIM];
   logic [31:0]       sample_mem_ff [MAX_DIM];
   logic [31:0]       w_rd_ff, b_rd_ff;
   logic              w_we, b_we;
   logic [31:0]       w_wdata;
   logic [ADDR_W-1:0] rd_addr;

   // shared units
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod, prod_sh, w_ext, bias_ext;
   logic [30:0]          fac_c;
   logic                 div_start, div_busy, div_done;
   logic [pss_pkg::DIV_NUM_W-1:0] div_num, div_q;
   logic [pss_pkg::DIV_DEN_W-1:0] div_den;
   logic [64:0]          dprod;

   logic [LEN_W-1:0] len;
   logic             req_acc, out_free, bias_on;

   pss_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p(prod));

   pss_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .busy(div_busy), .done(div_done), .quot(div_q)
   );

   // effective sample length, capped by buffer depth
   assign len = (32'(alen_ff) < 32'(MAX_DIM)) ? LEN_W'(alen_ff) : LEN_W'(MAX_DIM);
   assign bias_on  = (bmult_ff != '0);
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign out_free = !rv_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   assign prod_sh  = prod >>> 16;
   assign fac_c    = pss_pkg::sat_fac(prod_sh);
   assign w_ext    = PW'($signed(w_rd_ff));
   assign bias_ext = PW'($signed(bias_ff));
   // (t+offset)*lambda, high bit of the sum folded in by a shifted add
   assign dprod    = {1'b0, prod[63:0]} + (s_ff[32] ? {1'b0, lambda_ff, 32'd0} : 65'd0);

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MULS: begin
            mul_a = $signed({1'b0, s_ff[31:0]});
            mul_b = $signed({1'b0, lambda_ff});
         end
         S_SHMUL: begin
            mul_a = $signed(MW'(eta_ff));
            mul_b = MW'($signed(w_rd_ff));
         end
         S_BS1: begin
            mul_a = $signed(MW'(eta_ff));
            mul_b = $signed(MW'(brate_ff));
         end
         S_BS2: begin
            mul_a = $signed(MW'(fac_c));
            mul_b = MW'($signed(bias_ff));
         end
         S_DOTMUL: begin
            mul_a = MW'($signed(w_rd_ff));
            mul_b = MW'($signed(b_rd_ff));
         end
         S_DB1: begin
            mul_a = MW'($signed(bias_ff));
            mul_b = $signed(MW'(bmult_ff));
         end
         S_UPMUL: begin
            mul_a = $signed(MW'(rate_ff));
            mul_b = MW'($signed(b_rd_ff));
         end
         S_BU1: begin
            mul_a = $signed(MW'(rate_ff));
            mul_b = $signed(MW'(brate_ff));
         end
         S_BU2: begin
            mul_a = $signed(MW'(fac_c));
            mul_b = $signed(MW'(bmult_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // main sequencer
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      ovf_in    = ovf_ff;
      iter_in   = iter_ff;
      mod_in    = mod_ff;
      bias_in   = bias_ff;
      lbl_in    = lbl_ff;
      ridx_in   = ridx_ff;
      s_in      = s_ff;
      rate_in   = rate_ff;
      eta_in    = eta_ff;
      acc_in    = acc_ff;
      score_in  = score_ff;
      viol_in   = viol_ff;
      rkind_in  = rkind_ff;
      rword_in  = rword_ff;
      rv_in     = rv_ff && !rsp_chan.ready;
      ok_in     = ok_ff;
      ow_in     = ow_ff;
      ov_in     = ov_ff;
      os_in     = os_ff;
      oi_in     = oi_ff;
      ol_in     = ol_ff;
      w_we      = 1'b0;
      w_wdata   = '0;
      b_we      = 1'b0;
      div_start = 1'b0;
      div_num   = {1'b1, 48'd0};
      div_den   = {1'b0, dprod[63:0]};
      rd_addr   = idx_ff[ADDR_W-1:0];

      case (state_ff)
         S_CLEAR: begin
            w_we   = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LEN_W'(MAX_DIM - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               if (req_chan.op == pss_pkg::OP_READ) begin
                  ridx_in  = req_chan.read_index;
                  state_in = S_RDW;
               end else begin
                  if (pos_ff < len) begin
                     b_we   = 1'b1;
                     pos_in = pos_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (req_chan.last_element) begin
                     lbl_in   = req_chan.label_positive;
                     s_in     = {1'b0, iter_ff} + {1'b0, offset_ff};
                     rkind_in = pss_pkg::KIND_STATUS;
                     acc_in   = '0;
                     state_in = S_MULS;
                  end
               end
            end
         end
         S_RDW: begin
            rd_addr  = ADDR_W'(32'(ridx_ff));
            state_in = S_RDD;
         end
         S_RDD: begin
            rkind_in = pss_pkg::KIND_READ;
            if (32'(ridx_ff) < 32'(len)) rword_in = w_rd_ff;
            else if (32'(ridx_ff) == 32'(len)) rword_in = bias_ff;
            else rword_in = '0;
            state_in = S_DONE;
         end
         S_MULS: begin
            state_in = S_MULW;
         end
         S_MULW: begin
            if ((s_ff == '0) || (lambda_ff == '0)) begin
               rate_in  = pss_pkg::RATE_MAX;
               state_in = S_PRESH;
            end else if (dprod[64]) begin
               rate_in  = '0;
               state_in = S_PRESH;
            end else begin
               div_start = 1'b1;
               state_in  = S_DRATE;
            end
         end
         S_DRATE: begin
            if (div_done) begin
               rate_in  = (div_q > pss_pkg::DIV_NUM_W'(pss_pkg::RATE_MAX)) ?
                          pss_pkg::RATE_MAX : div_q[30:0];
               state_in = S_PRESH;
            end
         end
         S_PRESH: begin
            div_num = pss_pkg::DIV_NUM_W'(pss_pkg::ETA_NUM);
            div_den = pss_pkg::DIV_DEN_W'(s_ff);
            idx_in  = '0;
            if (mod_ff != '0) begin
               state_in = S_DOTCHK;
            end else if (s_ff == '0) begin
               eta_in   = pss_pkg::ETA_NUM;
               state_in = S_SHCHK;
            end else begin
               div_start = 1'b1;
               state_in  = S_DETA;
            end
         end
         S_DETA: begin
            if (div_done) begin
               eta_in   = div_q[EW-1:0];
               state_in = S_SHCHK;
            end
         end
         // shrink pass over all active weights
         S_SHCHK: begin
            if (idx_ff < len) state_in = S_SHRD;
            else if (bias_on) state_in = S_BS1;
            else begin
               idx_in   = '0;
               state_in = S_DOTCHK;
            end
         end
         S_SHRD:  state_in = S_SHMUL;
         S_SHMUL: state_in = S_SHWR;
         S_SHWR: begin
            w_we     = 1'b1;
            w_wdata  = pss_pkg::sat32(w_ext - prod_sh);
            idx_in   = idx_ff + 1'b1;
            state_in = S_SHCHK;
         end
         S_BS1: state_in = S_BS2;
         S_BS2: state_in = S_BS3;
         S_BS3: begin
            bias_in  = pss_pkg::sat32(bias_ext - prod_sh);
            idx_in   = '0;
            state_in = S_DOTCHK;
         end
         // dot product over the features that arrived
         S_DOTCHK: begin
            if (idx_ff < pos_ff) state_in = S_DOTRD;
            else if (bias_on) state_in = S_DB1;
            else state_in = S_SCORE;
         end
         S_DOTRD:  state_in = S_DOTMUL;
         S_DOTMUL: state_in = S_DOTACC;
         S_DOTACC: begin
            acc_in   = acc_ff + prod_sh;
            idx_in   = idx_ff + 1'b1;
            state_in = S_DOTCHK;
         end
         S_DB1: state_in = S_DB2;
         S_DB2: begin
            acc_in   = acc_ff + prod_sh;
            state_in = S_SCORE;
         end
         S_SCORE: begin
            score_in = pss_pkg::sat32(acc_ff);
            viol_in  = lbl_ff ? ($signed(score_in) < pss_pkg::ONE_Q16)
                              : ($signed(score_in) > -pss_pkg::ONE_Q16);
            idx_in   = '0;
            state_in = viol_in ? S_UPCHK : S_DONE;
         end
         // sub-gradient step
         S_UPCHK: begin
            if (idx_ff < pos_ff) state_in = S_UPRD;
            else if (bias_on) state_in = S_BU1;
            else state_in = S_DONE;
         end
         S_UPRD:  state_in = S_UPMUL;
         S_UPMUL: state_in = S_UPWR;
         S_UPWR: begin
            w_we     = 1'b1;
            w_wdata  = pss_pkg::sat32(lbl_ff ? (w_ext + prod_sh) : (w_ext - prod_sh));
            idx_in   = idx_ff + 1'b1;
            state_in = S_UPCHK;
         end
         S_BU1: state_in = S_BU2;
         S_BU2: state_in = S_BU3;
         S_BU3: begin
            bias_in  = pss_pkg::sat32(lbl_ff ? (bias_ext + prod_sh) : (bias_ext - prod_sh));
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rv_in = 1'b1;
               ok_in = rkind_ff;
               if (rkind_ff == pss_pkg::KIND_READ) begin
                  ow_in = rword_ff;
                  ov_in = 1'b0;
                  os_in = '0;
                  oi_in = '0;
                  ol_in = 1'b0;
               end else begin
                  ow_in   = '0;
                  ov_in   = viol_ff;
                  os_in   = score_ff;
                  oi_in   = iter_ff + 1'b1;
                  ol_in   = ovf_ff;
                  iter_in = iter_ff + 1'b1;
                  // phase within the shrink period; a count wrap restarts it
                  if ((iter_ff == '1) || (mod_ff == pss_pkg::SHRINK_PERIOD - 1'b1)) begin
                     mod_in = '0;
                  end else begin
                     mod_in = mod_ff + 1'b1;
                  end
                  pos_in = '0;
                  ovf_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         idx_ff    <= '0;
         pos_ff    <= '0;
         ovf_ff    <= 1'b0;
         iter_ff   <= '0;
         mod_ff    <= '0;
         bias_ff   <= '0;
         rv_ff     <= 1'b0;
         lambda_ff <= pss_pkg::LAMBDA_RST;
         offset_ff <= pss_pkg::OFFSET_RST;
         bmult_ff  <= pss_pkg::BIAS_MULT_RST;
         brate_ff  <= pss_pkg::BIAS_RATE_RST;
         alen_ff   <= pss_pkg::ACTIVE_LEN_RST;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pos_ff   <= pos_in;
         ovf_ff   <= ovf_in;
         iter_ff  <= iter_in;
         mod_ff   <= mod_in;
         bias_ff  <= bias_in;
         rv_ff    <= rv_in;
         if (csr_we) begin
            case (csr_index)
               pss_pkg::REG_LAMBDA:     lambda_ff <= csr_wdata;
               pss_pkg::REG_OFFSET:     offset_ff <= csr_wdata;
               pss_pkg::REG_BIAS_MULT:  bmult_ff  <= csr_wdata[30:0];
               pss_pkg::REG_BIAS_RATE:  brate_ff  <= csr_wdata[30:0];
               pss_pkg::REG_ACTIVE_LEN: alen_ff   <= csr_wdata[10:0];
               default: ;
            endcase
         end
      end
      lbl_ff   <= lbl_in;
      ridx_ff  <= ridx_in;
      s_ff     <= s_in;
      rate_ff  <= rate_in;
      eta_ff   <= eta_in;
      acc_ff   <= acc_in;
      score_ff <= score_in;
      viol_ff  <= viol_in;
      rkind_ff <= rkind_in;
      rword_ff <= rword_in;
      ok_ff    <= ok_in;
      ow_ff    <= ow_in;
      ov_ff    <= ov_in;
      os_ff    <= os_in;
      oi_ff    <= oi_in;
      ol_ff    <= ol_in;
   end

   // weight memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (w_we) weight_mem_ff[idx_ff[ADDR_W-1:0]] <= w_wdata;
      w_rd_ff <= weight_mem_ff[rd_addr];
   end

   // sample buffer: written as features arrive, read during the passes
   always_ff @(posedge clock) begin
      if (b_we) sample_mem_ff[pos_ff[ADDR_W-1:0]] <= req_chan.feature_value;
      b_rd_ff <= sample_mem_ff[idx_ff[ADDR_W-1:0]];
   end

   assign rsp_chan.valid           = rv_ff;
   assign rsp_chan.kind            = ok_ff;
   assign rsp_chan.weight_value    = ow_ff;
   assign rsp_chan.margin_violated = ov_ff;
   assign rsp_chan.score           = os_ff;
   assign rsp_chan.iteration       = oi_ff;
   assign rsp_chan.length_error    = ol_ff;

   `SVM_ASSERT_IMP(a_div_owner, clock, reset, div_busy, (state_ff == S_DRATE) || (state_ff == S_DETA), "divider busy outside a divide step")
   `SVM_ASSERT_IMP(a_weight_write, clock, reset, w_we, (state_ff == S_CLEAR) || (state_ff == S_SHWR) || (state_ff == S_UPWR), "weight write outside a pass")
   `SVM_ASSERT_NXT(a_last_starts, clock, reset, req_acc && (req_chan.op == pss_pkg::OP_FEATURE) && req_chan.last_element, state_ff == S_MULS, "last word did not start an iteration")
   `SVM_ASSERT_NXT(a_done_loads, clock, reset, (state_ff == S_DONE) && out_free, rv_ff && (state_ff == S_IDLE), "finished word not loaded")
endmodule
